>>> src/ssp_pkg.sv
// Shared types and constants for the spindle speed PWM controller.
`timescale 1ns / 1ps

package ssp_pkg;

	localparam int RPM_W      = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int PROD_W     = 2 * RPM_W;
	localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_CW  = 2'd1;

	localparam logic [RPM_W-1:0] RST_RPM_MIN       = 16'd0;
	localparam logic [RPM_W-1:0] RST_RPM_MAX       = 16'd1000;
	localparam logic             RST_LASER_MODE    = 1'b0;
	localparam logic             RST_INVERT_ENABLE = 1'b0;
	localparam logic [RPM_W-1:0] RST_PWM_TOP       = 16'hFFFF;
	localparam logic [RPM_W-1:0] RST_PWM_OFF_LEVEL = 16'd0;
	localparam logic [RPM_W-1:0] RST_PWM_MIN_LEVEL = 16'd1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RPM_MIN       = 3'd0,
		REG_RPM_MAX       = 3'd1,
		REG_LASER_MODE    = 3'd2,
		REG_INVERT_ENABLE = 3'd3,
		REG_PWM_TOP       = 3'd4,
		REG_PWM_OFF_LEVEL = 3'd5,
		REG_PWM_MIN_LEVEL = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm_min;
		logic [RPM_W-1:0] rpm_max;
		logic             laser_mode;
		logic             invert_enable;
		logic [RPM_W-1:0] pwm_top;
		logic [RPM_W-1:0] pwm_off_level;
		logic [RPM_W-1:0] pwm_min_level;
	} ssp_cfg_t;

	typedef struct packed {
		logic             done;
		logic [RPM_W-1:0] quotient;
	} div_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} ssp_state_t;

endpackage

>>> src/ssp_cfg_regs.sv
// Configuration register file with write decode.
`timescale 1ns / 1ps

module ssp_cfg_regs import ssp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	output ssp_cfg_t              cfg
);

	ssp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_min       <= RST_RPM_MIN;
			cfg_q.rpm_max       <= RST_RPM_MAX;
			cfg_q.laser_mode    <= RST_LASER_MODE;
			cfg_q.invert_enable <= RST_INVERT_ENABLE;
			cfg_q.pwm_top       <= RST_PWM_TOP;
			cfg_q.pwm_off_level <= RST_PWM_OFF_LEVEL;
			cfg_q.pwm_min_level <= RST_PWM_MIN_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RPM_MIN:       cfg_q.rpm_min       <= cfg_wdata[RPM_W-1:0];
				REG_RPM_MAX:       cfg_q.rpm_max       <= cfg_wdata[RPM_W-1:0];
				REG_LASER_MODE:    cfg_q.laser_mode    <= cfg_wdata[0];
				REG_INVERT_ENABLE: cfg_q.invert_enable <= cfg_wdata[0];
				REG_PWM_TOP:       cfg_q.pwm_top       <= cfg_wdata[RPM_W-1:0];
				REG_PWM_OFF_LEVEL: cfg_q.pwm_off_level <= cfg_wdata[RPM_W-1:0];
				REG_PWM_MIN_LEVEL: cfg_q.pwm_min_level <= cfg_wdata[RPM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/ssp_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ssp_divider import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [RPM_W-1:0]  divisor,
	output div_result_t       res
);

	// Only the low RPM_W quotient bits are kept. When the upper dividend half is below
	// the divisor the upper quotient bits are zero, so skip the first RPM_W steps.
	logic [RPM_W-1:0]     rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [RPM_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [RPM_W:0] shifted;
	logic [RPM_W:0] trial;
	logic           fits;
	logic           short_div;

	always_comb begin
		short_div = (dividend[PROD_W-1:RPM_W] < divisor);
		shifted   = {rem_q, quo_q[PROD_W-1]};
		trial     = shifted - {1'b0, den_q};
		fits      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= short_div ? DIV_CNT_W'(RPM_W) : DIV_CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			if (short_div) begin
				rem_q <= dividend[PROD_W-1:RPM_W];
				quo_q <= {dividend[RPM_W-1:0], {RPM_W{1'b0}}};
			end else begin
				rem_q <= '0;
				quo_q <= dividend;
			end
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[RPM_W-1:0] : shifted[RPM_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q[RPM_W-1:0];

endmodule

>>> src/spindle_speed_pwm_controller.sv
// Top level: command sequencer, spindle state and result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  command   | in_valid / in_ready       | spin_mode, rpm_request, abort_active
//  result    | out_valid / out_ready     | pwm_level, pwm_on, enable_pin,
//            |                           | direction_pin, reported_speed, report_now
//  config    | cfg_we (no wait)          | cfg_addr, cfg_wdata
//
// Off, abort and fixed speed cases pass through idle, evaluate and output.
// A speed in the linear range goes through idle, evaluate, multiply, divider load,
// 16 divide steps plus a done cycle, output; the divider sets the rate.
// A request above rpm_max wraps the product; 32 divide steps if its top half >= divisor.
// A command is taken only in the idle state; a result waiting on out_ready holds in the
// output register and stalls the block only if the next result is ready before it drains.
// Reset puts the spindle off with the level at full scale.
`timescale 1ns / 1ps

module spindle_speed_pwm_controller import ssp_pkg::*; #(
	parameter int LEVEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            spin_mode,
	input  logic [RPM_W-1:0]      rpm_request,
	input  logic                  abort_active,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RPM_W-1:0]      pwm_level,
	output logic                  pwm_on,
	output logic                  enable_pin,
	output logic                  direction_pin,
	output logic [RPM_W-1:0]      reported_speed,
	output logic                  report_now,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	ssp_cfg_t    cfg;
	div_result_t div_res;

	ssp_state_t state_q, state_d;
	logic       div_start;
	logic       out_load;
	logic       in_accept;

	// Latched command
	logic [1:0]       mode_q;
	logic [RPM_W-1:0] rpm_q;
	logic             abort_q;

	// Spindle state
	logic [LEVEL_BITS-1:0] level_q;
	logic                  pwm_en_q;
	logic                  enable_q;
	logic                  dir_q;
	logic [RPM_W-1:0]      speed_q;

	// Result register
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic                  out_pwm_on_q;
	logic                  out_enable_q;
	logic                  out_dir_q;
	logic [RPM_W-1:0]      out_speed_q;
	logic                  out_report_q;

	logic [PROD_W-1:0]     prod_q;

	logic                  ccw_in;
	logic                  ccw_q;
	logic                  linear;
	logic [LEVEL_BITS-1:0] top_l, off_l, min_l, quo_l;
	logic [LEVEL_BITS-1:0] lvl_sel;
	logic [RPM_W-1:0]      spd_sel;
	logic [LEVEL_BITS-1:0] lvl_new;
	logic [PROD_W-1:0]     span;
	logic [PROD_W-1:0]     prod_c;

	ssp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ssp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (cfg.rpm_max - cfg.rpm_min),
		.res      (div_res)
	);

	assign in_accept = in_valid && in_ready;
	assign ccw_in    = (spin_mode != MODE_CW);
	assign ccw_q     = (mode_q != MODE_CW);

	always_comb begin
		top_l = cfg.pwm_top[LEVEL_BITS-1:0];
		off_l = cfg.pwm_off_level[LEVEL_BITS-1:0];
		min_l = cfg.pwm_min_level[LEVEL_BITS-1:0];
		quo_l = div_res.quotient[LEVEL_BITS-1:0];

		linear = (rpm_q != cfg.rpm_max) && (cfg.rpm_min < cfg.rpm_max)
			&& (rpm_q > cfg.rpm_min);

		// Fixed cases, priority as listed; the last arm is a request at or below minimum.
		if (rpm_q == cfg.rpm_max) begin
			lvl_sel = LEVEL_BITS'(1);
			spd_sel = cfg.rpm_max;
		end else if (cfg.rpm_min >= cfg.rpm_max) begin
			lvl_sel = top_l;
			spd_sel = cfg.rpm_max;
		end else if (rpm_q == '0) begin
			lvl_sel = off_l;
			spd_sel = '0;
		end else begin
			lvl_sel = min_l;
			spd_sel = cfg.rpm_min;
		end

		lvl_new = (state_q == ST_DIV) ? quo_l : lvl_sel;
		// A request above rpm_max wraps the span and the product at 32 bits.
		span    = {{(PROD_W-RPM_W){1'b0}}, cfg.rpm_max} - {{(PROD_W-RPM_W){1'b0}}, rpm_q};
		prod_c  = {{(PROD_W-RPM_W){1'b0}}, cfg.pwm_top} * span;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (!abort_q && (mode_q != MODE_OFF) && linear) state_d = ST_MUL;
				else state_d = ST_OUT;
			end
			ST_MUL:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (div_res.done) state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_LOAD: div_start = 1'b1;
			ST_OUT:  out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q  <= spin_mode;
			abort_q <= abort_active;
			rpm_q   <= (cfg.laser_mode && ccw_in) ? '0 : rpm_request;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= {LEVEL_BITS{1'b1}};
			pwm_en_q <= 1'b0;
			enable_q <= RST_INVERT_ENABLE;
			dir_q    <= 1'b0;
			speed_q  <= '0;
		end else if (state_q == ST_EVAL && !abort_q) begin
			if (mode_q == MODE_OFF) begin
				speed_q  <= '0;
				pwm_en_q <= 1'b0;
				enable_q <= cfg.invert_enable;
			end else begin
				dir_q <= ccw_q;
				if (!linear) begin
					level_q  <= lvl_new;
					pwm_en_q <= (lvl_new != off_l);
					enable_q <= !cfg.invert_enable;
					speed_q  <= spd_sel;
				end
			end
		end else if (state_q == ST_DIV && div_res.done) begin
			level_q  <= lvl_new;
			pwm_en_q <= (lvl_new != off_l);
			enable_q <= !cfg.invert_enable;
			speed_q  <= rpm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q  <= level_q;
			out_pwm_on_q <= pwm_en_q;
			out_enable_q <= enable_q;
			out_dir_q    <= dir_q;
			out_speed_q  <= speed_q;
			out_report_q <= !abort_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pwm_level      = RPM_W'(out_level_q);
	assign pwm_on         = out_pwm_on_q;
	assign enable_pin     = out_enable_q;
	assign direction_pin  = out_dir_q;
	assign reported_speed = out_speed_q;
	assign report_now     = out_report_q;

endmodule

>>> src/ssp_checker.sv
// Port-level checks for the spindle speed PWM controller, bound to the top level.
`timescale 1ns / 1ps

module ssp_checker import ssp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [RPM_W-1:0] pwm_level,
	input logic [RPM_W-1:0] reported_speed
);

	// A taken command keeps the block busy through the evaluate state and on into the next state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready)
		else $error("command taken while previous command still in work");

	// A new result frees the command side in the same cycle.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while sequencer still busy");

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before transaction");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(pwm_level) && $stable(reported_speed))
		else $error("result payload changed while stalled");

endmodule

bind spindle_speed_pwm_controller ssp_checker u_ssp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.pwm_level      (pwm_level),
	.reported_speed (reported_speed)
);

>>> verif/spindle_speed_pwm_controller_tb.sv
// Self-checking testbench for the spindle speed PWM controller.
`timescale 1ns / 1ps

module spindle_speed_pwm_controller_tb;
	import ssp_pkg::*;

	localparam int          LEVEL_BITS      = 16;
	localparam logic [31:0] LEVEL_MASK      = (32'd1 << LEVEL_BITS) - 32'd1;
	localparam logic [1:0]  MODE_CCW        = 2'd2;
	localparam logic [1:0]  MODE_SPARE      = 2'd3;
	localparam int          N_PHASES        = 12;
	localparam int          ITEMS_PER_PHASE = 150;
	localparam int          MAX_WAIT        = 18;
	localparam int          HOLD_AT         = 600;
	localparam int          HOLD_CYCLES     = 300;
	localparam int          DRAIN_CYCLES    = 30;

	typedef struct packed {
		logic [1:0]       mode;
		logic [RPM_W-1:0] rpm;
		logic             abort_req;
	} spin_cmd_t;

	typedef struct packed {
		logic [RPM_W-1:0] level;
		logic             pwm_on;
		logic             en_pin;
		logic             dir_pin;
		logic [RPM_W-1:0] speed;
		logic             report;
	} spin_state_t;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_reg_t         sel;
		logic [CFG_W-1:0] value;
		spin_cmd_t        cmd;
		logic             typed;
		spin_state_t      want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            spin_mode = MODE_OFF;
	logic [RPM_W-1:0]      rpm_request = '0;
	logic                  abort_active = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [RPM_W-1:0]      pwm_level;
	logic                  pwm_on;
	logic                  enable_pin;
	logic                  direction_pin;
	logic [RPM_W-1:0]      reported_speed;
	logic                  report_now;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// shadow of the block: configuration and spindle state
	ssp_cfg_t         shadow_cfg;
	logic [RPM_W-1:0] spindle_level;
	logic             spindle_pwm_on;
	logic             spindle_en;
	logic             spindle_dir;
	logic [RPM_W-1:0] spindle_rpm;

	spin_state_t pending_pwm_states[$];
	spin_state_t head_state;
	plan_row_t   plan[$];
	bit          calm_tx = 1'b0;
	int          err_count = 0;
	int          results_seen = 0;

	spindle_speed_pwm_controller #(.LEVEL_BITS(LEVEL_BITS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.spin_mode     (spin_mode),
		.rpm_request   (rpm_request),
		.abort_active  (abort_active),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pwm_level     (pwm_level),
		.pwm_on        (pwm_on),
		.enable_pin    (enable_pin),
		.direction_pin (direction_pin),
		.reported_speed(reported_speed),
		.report_now    (report_now),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// Apply one command to the shadow state and return the state the block reports.
	function automatic spin_state_t predict_spindle(input spin_cmd_t c);
		logic [RPM_W-1:0] r;
		logic [31:0]      lvl;
		logic [31:0]      prod;
		logic             ccw;
		spin_state_t      res;
		r   = c.rpm;
		ccw = (c.mode != MODE_CW);
		lvl = '0;
		if (!c.abort_req) begin
			if (c.mode == MODE_OFF) begin
				spindle_rpm    = '0;
				spindle_pwm_on = 1'b0;
				spindle_en     = shadow_cfg.invert_enable;
			end else begin
				spindle_dir = ccw;
				if (shadow_cfg.laser_mode && ccw)
					r = '0;
				if (r == shadow_cfg.rpm_max) begin
					lvl         = 32'd1;
					spindle_rpm = shadow_cfg.rpm_max;
				end else if (shadow_cfg.rpm_min >= shadow_cfg.rpm_max) begin
					lvl         = 32'(shadow_cfg.pwm_top);
					spindle_rpm = shadow_cfg.rpm_max;
				end else if (r <= shadow_cfg.rpm_min) begin
					if (r == '0) begin
						lvl         = 32'(shadow_cfg.pwm_off_level);
						spindle_rpm = '0;
					end else begin
						lvl         = 32'(shadow_cfg.pwm_min_level);
						spindle_rpm = shadow_cfg.rpm_min;
					end
				end else begin
					// product wraps at 32 bits when the request is above rpm_max
					prod = 32'(shadow_cfg.pwm_top) * (32'(shadow_cfg.rpm_max) - 32'(r));
					lvl  = prod / (32'(shadow_cfg.rpm_max) - 32'(shadow_cfg.rpm_min));
					spindle_rpm = r;
				end
				spindle_level  = RPM_W'(lvl & LEVEL_MASK);
				spindle_pwm_on = (32'(spindle_level) !=
					(32'(shadow_cfg.pwm_off_level) & LEVEL_MASK));
				spindle_en     = ~shadow_cfg.invert_enable;
			end
		end
		res.level   = spindle_level;
		res.pwm_on  = spindle_pwm_on;
		res.en_pin  = spindle_en;
		res.dir_pin = spindle_dir;
		res.speed   = spindle_rpm;
		res.report  = ~c.abort_req;
		return res;
	endfunction

	function automatic plan_row_t cfg_row(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_CFG;
		row.sel   = sel;
		row.value = value;
		return row;
	endfunction

	function automatic plan_row_t cmd_row(input logic [1:0] mode, input logic [RPM_W-1:0] rpm,
			input logic abort_req);
		plan_row_t row;
		row               = '0;
		row.kind          = ROW_CMD;
		row.cmd.mode      = mode;
		row.cmd.rpm       = rpm;
		row.cmd.abort_req = abort_req;
		return row;
	endfunction

	function automatic plan_row_t chk_row(input logic [1:0] mode, input logic [RPM_W-1:0] rpm,
			input logic abort_req, input logic [RPM_W-1:0] level, input logic on,
			input logic en, input logic dir, input logic [RPM_W-1:0] speed);
		plan_row_t row;
		row = cmd_row(mode, rpm, abort_req);
		row.typed        = 1'b1;
		row.want.level   = level;
		row.want.pwm_on  = on;
		row.want.en_pin  = en;
		row.want.dir_pin = dir;
		row.want.speed   = speed;
		row.want.report  = ~abort_req;
		return row;
	endfunction

	function automatic logic [CFG_W-1:0] pick_level();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return 16'd1;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		err_count++;
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		case (sel)
			REG_RPM_MIN:       shadow_cfg.rpm_min       = value;
			REG_RPM_MAX:       shadow_cfg.rpm_max       = value;
			REG_LASER_MODE:    shadow_cfg.laser_mode    = value[0];
			REG_INVERT_ENABLE: shadow_cfg.invert_enable = value[0];
			REG_PWM_TOP:       shadow_cfg.pwm_top       = value;
			REG_PWM_OFF_LEVEL: shadow_cfg.pwm_off_level = value;
			REG_PWM_MIN_LEVEL: shadow_cfg.pwm_min_level = value;
			default: ;
		endcase
	endtask

	// Drop valid and hold until every expected transaction has drained.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pwm_states.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_cmd(input spin_cmd_t c, input bit typed, input spin_state_t want);
		int          gap;
		spin_state_t predicted;
		gap = calm_tx ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		spin_mode    <= c.mode;
		rpm_request  <= c.rpm;
		abort_active <= c.abort_req;
		do @(posedge clk); while (!in_ready);
		predicted = predict_spindle(c);
		pending_pwm_states.push_back(typed ? want : predicted);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pwm_states.size() == 0) begin
				flag_mismatch("result with none expected", 32'(pwm_level), 32'd0);
			end else begin
				head_state = pending_pwm_states.pop_front();
				if (pwm_level !== head_state.level)
					flag_mismatch("pwm_level", 32'(pwm_level), 32'(head_state.level));
				if (pwm_on !== head_state.pwm_on)
					flag_mismatch("pwm_on", 32'(pwm_on), 32'(head_state.pwm_on));
				if (enable_pin !== head_state.en_pin)
					flag_mismatch("enable_pin", 32'(enable_pin), 32'(head_state.en_pin));
				if (direction_pin !== head_state.dir_pin)
					flag_mismatch("direction_pin", 32'(direction_pin), 32'(head_state.dir_pin));
				if (reported_speed !== head_state.speed)
					flag_mismatch("reported_speed", 32'(reported_speed), 32'(head_state.speed));
				if (report_now !== head_state.report)
					flag_mismatch("report_now", 32'(report_now), 32'(head_state.report));
			end
			results_seen++;
		end
	end

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin
		int  stall;
		int  drained;
		bit  held;
		drained = 0;
		held    = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (drained == HOLD_AT && !held) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end else if (((drained / 128) % 4) == 3) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			drained++;
		end
	end

	// command side
	initial begin
		spin_cmd_t        c;
		spin_state_t      none;
		plan_row_t        row;
		logic [RPM_W-1:0] lo;
		logic [RPM_W-1:0] hi;
		logic [RPM_W-1:0] r;
		bit               cfg_open;

		shadow_cfg.rpm_min       = RST_RPM_MIN;
		shadow_cfg.rpm_max       = RST_RPM_MAX;
		shadow_cfg.laser_mode    = RST_LASER_MODE;
		shadow_cfg.invert_enable = RST_INVERT_ENABLE;
		shadow_cfg.pwm_top       = RST_PWM_TOP;
		shadow_cfg.pwm_off_level = RST_PWM_OFF_LEVEL;
		shadow_cfg.pwm_min_level = RST_PWM_MIN_LEVEL;
		spindle_level  = RPM_W'(32'(RST_PWM_TOP) & LEVEL_MASK);
		spindle_pwm_on = 1'b0;
		spindle_en     = RST_INVERT_ENABLE;
		spindle_dir    = 1'b0;
		spindle_rpm    = '0;
		none     = '0;
		cfg_open = 1'b0;

		plan = '{
			// reset state, abort holds it
			chk_row(MODE_CW,    16'd500,   1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0),
			chk_row(MODE_CW,    16'd1000,  1'b0, 16'd1,    1'b1, 1'b1, 1'b0, 16'd1000),
			chk_row(MODE_CCW,   16'd0,     1'b0, 16'd0,    1'b0, 1'b1, 1'b1, 16'd0),
			chk_row(MODE_OFF,   16'd777,   1'b0, 16'd0,    1'b0, 1'b0, 1'b1, 16'd0),
			cmd_row(MODE_CW,    16'd500,   1'b0),
			cmd_row(MODE_SPARE, 16'd1,     1'b0),
			cmd_row(MODE_CW,    16'hFFFF,  1'b0),
			cmd_row(MODE_CW,    16'd999,   1'b0),
			cmd_row(MODE_SPARE, 16'd0,     1'b1),
			cfg_row(REG_RPM_MIN, 16'd100),
			chk_row(MODE_CW,    16'd50,    1'b0, 16'd1,    1'b1, 1'b1, 1'b0, 16'd100),
			chk_row(MODE_CCW,   16'd100,   1'b0, 16'd1,    1'b1, 1'b1, 1'b1, 16'd100),
			cmd_row(MODE_CW,    16'd101,   1'b0),
			cfg_row(REG_LASER_MODE, 16'd1),
			chk_row(MODE_CCW,   16'd800,   1'b0, 16'd0,    1'b0, 1'b1, 1'b1, 16'd0),
			chk_row(MODE_SPARE, 16'hFFFF,  1'b0, 16'd0,    1'b0, 1'b1, 1'b1, 16'd0),
			cmd_row(MODE_CW,    16'd800,   1'b0),
			// new polarity must not move the pin until the next command that is not aborted
			cfg_row(REG_INVERT_ENABLE, 16'd1),
			cmd_row(MODE_OFF,   16'd0,     1'b1),
			cmd_row(MODE_OFF,   16'd0,     1'b0),
			cmd_row(MODE_CW,    16'd300,   1'b0),
			cfg_row(REG_PWM_TOP, 16'd0),
			cmd_row(MODE_CW,    16'd500,   1'b0),
			cfg_row(REG_PWM_OFF_LEVEL, 16'hFFFF),
			cfg_row(REG_PWM_MIN_LEVEL, 16'hFFFF),
			cmd_row(MODE_CW,    16'd50,    1'b0),
			cfg_row(REG_RPM_MAX, 16'd100),
			cmd_row(MODE_CW,    16'd0,     1'b0),
			cfg_row(REG_RPM_MIN, 16'hFFFF),
			cfg_row(REG_RPM_MAX, 16'hFFFF),
			cfg_row(REG_PWM_TOP, 16'hFFFF),
			chk_row(MODE_CW,    16'hFFFF,  1'b0, 16'd1,    1'b1, 1'b0, 1'b0, 16'hFFFF),
			chk_row(MODE_CW,    16'd0,     1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'hFFFF),
			cfg_row(REG_RPM_MIN, 16'd0),
			cfg_row(REG_RPM_MAX, 16'd0),
			chk_row(MODE_CCW,   16'd4000,  1'b0, 16'd1,    1'b1, 1'b0, 1'b1, 16'd0),
			cmd_row(MODE_CW,    16'hFFFF,  1'b0)
		};

		wait (arst_n);
		@(posedge clk);

		foreach (plan[k]) begin
			row = plan[k];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open)
					wait_idle();
				write_reg(row.sel, row.value);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_we <= 1'b0;
				cfg_open = 1'b0;
				send_cmd(row.cmd, row.typed, row.want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: begin
					lo = '0;
					hi = '1;
				end
				1: begin
					lo = RPM_W'($urandom);
					hi = lo;
				end
				2: begin
					lo = RPM_W'($urandom_range(1, 65535));
					hi = RPM_W'($urandom_range(0, int'(lo) - 1));
				end
				3: begin
					lo = RPM_W'($urandom_range(0, 3000));
					hi = lo + RPM_W'($urandom_range(1, 3000));
				end
				default: begin
					lo = RPM_W'($urandom_range(0, 65534));
					hi = RPM_W'($urandom_range(int'(lo) + 1, 65535));
				end
			endcase
			write_reg(REG_RPM_MIN, lo);
			write_reg(REG_RPM_MAX, hi);
			write_reg(REG_LASER_MODE, CFG_W'($urandom));
			write_reg(REG_INVERT_ENABLE, CFG_W'($urandom));
			write_reg(REG_PWM_TOP, pick_level());
			write_reg(REG_PWM_OFF_LEVEL, pick_level());
			write_reg(REG_PWM_MIN_LEVEL, pick_level());
			cfg_we  <= 1'b0;
			calm_tx = ((ph % 4) == 2);

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				case ($urandom_range(0, 9))
					0: r = '0;
					1: r = shadow_cfg.rpm_min;
					2: r = shadow_cfg.rpm_max;
					3: r = shadow_cfg.rpm_min + 16'd1;
					4: r = shadow_cfg.rpm_max - 16'd1;
					5: r = '1;
					6, 7: r = RPM_W'($urandom);
					default: begin
						if (shadow_cfg.rpm_min < shadow_cfg.rpm_max)
							r = shadow_cfg.rpm_min + RPM_W'($urandom_range(0,
								int'(shadow_cfg.rpm_max) - int'(shadow_cfg.rpm_min)));
						else
							r = RPM_W'($urandom);
					end
				endcase
				c.mode      = 2'($urandom_range(0, 3));
				c.rpm       = r;
				c.abort_req = ($urandom_range(0, 7) == 0);
				send_cmd(c, 1'b0, none);
			end
		end

		in_valid <= 1'b0;
		while (pending_pwm_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> spindle_speed_pwm_controller.f
src/ssp_pkg.sv
src/ssp_cfg_regs.sv
src/ssp_divider.sv
src/spindle_speed_pwm_controller.sv
src/ssp_checker.sv
verif/spindle_speed_pwm_controller_tb.sv
